@@ rtl/xr128_pkg.sv @@
`timescale 1ns / 1ps

package xr128_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  // Operation carried in tuser.
  localparam logic OpDraw = 1'b0;
  localparam logic OpSeed = 1'b1;

  // Mixer constants of the seeding hash.
  localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulOne  = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulTwo  = 64'h94d049bb133111eb;

  localparam int unsigned MixShiftOne   = 30;
  localparam int unsigned MixShiftTwo   = 27;
  localparam int unsigned MixShiftThree = 31;

  // Generator step.
  localparam int unsigned RotA   = 24;
  localparam int unsigned ShiftB = 16;
  localparam int unsigned RotB   = 37;

  // Double conversion.
  localparam int unsigned FracW   = 52;
  localparam int unsigned ExpW    = 11;
  localparam int unsigned NormW   = FracW + 1;
  localparam int unsigned DropW   = WordW - FracW;
  localparam int unsigned ShCntW  = 6;
  localparam int unsigned NormSteps = 6;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] bits;
  } norm_status_t;

endpackage

@@ rtl/xoroshiro128plus_generator.sv @@
`timescale 1ns / 1ps

// Pseudo-random generator with 128 bits of state. A beat with tuser set seeds
// the state through two rounds of a 64-bit mixing hash and gives no output; a
// beat with tuser clear gives one output beat carrying the 64-bit sum of the
// state words and the double bit pattern of a uniform value in (0,1]. Both
// jobs run on one registered 32x32 multiplier and one shift-search normalizer
// under a small sequencer, one beat at a time: no new beat is taken until the
// current one is done. For a draw, the sum and state step happen at the
// accepting edge, then the StNStart state loads the integer to normalize, six
// normalizer steps follow and the StNorm state loads the output register. A
// draw waits for the output register to be free before loading it. In a seed,
// each mixing round is one add, three xor-shifts and two 64-bit modular
// products, each built from three 32x32 partial products. After reset the
// block runs the same seeding pass with a zero seed, during which it takes no
// beat.
module xoroshiro128plus_generator
  import xr128_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [WordW-1:0]     s_axis_tdata_i,  // [63:0] seed_value
  input  logic                 s_axis_tuser_i,  // [0] operation
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [2*WordW-1:0]   m_axis_tdata_o   // [63:0] random_word, [127:64] uniform_bits
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMixAdd = 3'd1;
  localparam logic [2:0] StMixXs  = 3'd2;
  localparam logic [2:0] StMixMul = 3'd3;
  localparam logic [2:0] StNStart = 3'd4;
  localparam logic [2:0] StNorm   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [1:0]         round_q, round_d;
  logic [1:0]         ph_q, ph_d;
  logic               half_q, half_d;
  logic [WordW-1:0]   x_q, x_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [WordW-1:0]   a_q, a_d;
  logic [WordW-1:0]   b_q, b_d;
  logic [WordW-1:0]   sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [2*WordW-1:0] out_data_q, out_data_d;

  logic [WordW-1:0]   mul_const;
  logic [WordW-1:0]   xs_val;
  logic [HalfW-1:0]   mul_a, mul_b;
  logic [2*HalfW-1:0] prod;
  logic [WordW-1:0]   prod_hi;
  logic [WordW-1:0]   bx;
  logic               in_fire;
  logic               out_free;
  logic               norm_start;
  logic [NormW-1:0]   norm_n;
  norm_status_t       norm_st;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    case (round_q)
      2'd0:    xs_val = x_q ^ (x_q >> MixShiftOne);
      2'd1:    xs_val = x_q ^ (x_q >> MixShiftTwo);
      default: xs_val = x_q ^ (x_q >> MixShiftThree);
    endcase
  end

  assign mul_const = (round_q == 2'd0) ? MixMulOne : MixMulTwo;

  // Low 64 bits of a 64x64 product: low*low plus both cross terms moved up 32.
  always_comb begin
    case (ph_q)
      2'd0:    begin mul_a = x_q[HalfW-1:0];     mul_b = mul_const[HalfW-1:0];     end
      2'd1:    begin mul_a = x_q[HalfW-1:0];     mul_b = mul_const[WordW-1:HalfW]; end
      default: begin mul_a = x_q[WordW-1:HalfW]; mul_b = mul_const[HalfW-1:0];     end
    endcase
  end

  xr128_mul32 u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  assign prod_hi = {prod[HalfW-1:0], {HalfW{1'b0}}};
  assign bx      = a_q ^ b_q;

  assign norm_start = (state_q == StNStart);
  assign norm_n     = (NormW'(1) << FracW) - NormW'(sum_q[WordW-1:DropW]);

  xr128_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .n_i      (norm_n),
    .status_o (norm_st)
  );

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    ph_d        = ph_q;
    half_d      = half_q;
    x_d         = x_q;
    acc_d       = acc_q;
    a_d         = a_q;
    b_d         = b_q;
    sum_d       = sum_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser_i == OpDraw) begin
            sum_d   = a_q + b_q;
            a_d     = ((a_q << RotA) | (a_q >> (WordW - RotA))) ^ bx ^ (bx << ShiftB);
            b_d     = (bx << RotB) | (bx >> (WordW - RotB));
            state_d = StNStart;
          end else begin
            x_d     = s_axis_tdata_i;
            round_d = '0;
            half_d  = 1'b0;
            state_d = StMixAdd;
          end
        end
      end
      StMixAdd: begin
        x_d     = x_q + GoldenStep;
        state_d = StMixXs;
      end
      StMixXs: begin
        x_d = xs_val;
        if (round_q == 2'd2) begin
          round_d = '0;
          if (!half_q) begin
            a_d     = xs_val;
            half_d  = 1'b1;
            state_d = StMixAdd;
          end else begin
            b_d     = xs_val;
            half_d  = 1'b0;
            state_d = StIdle;
          end
        end else begin
          ph_d    = '0;
          state_d = StMixMul;
        end
      end
      StMixMul: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0: ;
          2'd1: acc_d = prod;
          2'd2: acc_d = acc_q + prod_hi;
          default: begin
            x_d     = acc_q + prod_hi;
            round_d = round_q + 2'd1;
            state_d = StMixXs;
          end
        endcase
      end
      StNStart: begin
        state_d = StNorm;
      end
      StNorm: begin
        if (norm_st.done && out_free) begin
          out_data_d  = {norm_st.bits, sum_q};
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Reset starts a seeding pass with a zero seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StMixAdd;
      round_q     <= '0;
      ph_q        <= '0;
      half_q      <= 1'b0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      ph_q        <= ph_d;
      half_q      <= half_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    a_q        <= a_d;
    b_q        <= b_d;
    sum_q      <= sum_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ rtl/xr128_mul32.sv @@
`timescale 1ns / 1ps

module xr128_mul32
  import xr128_pkg::*;
(
  input  logic                 clk_i,
  input  logic [HalfW-1:0]     op_a_i,
  input  logic [HalfW-1:0]     op_b_i,
  output logic [2*HalfW-1:0]   prod_o
);

  logic [2*HalfW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/xr128_norm.sv @@
`timescale 1ns / 1ps

module xr128_norm
  import xr128_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NormW-1:0]   n_i,
  output norm_status_t       status_o
);

  logic [NormW-1:0]  val_q, val_d;
  logic [ShCntW-1:0] sh_q, sh_d;
  logic [2:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ShCntW-1:0] amt;
  logic              top_zero;
  logic [ExpW-1:0]   expo;

  // Binary search for the leading one: try shifts of 32, 16, 8, 4, 2 and 1.
  assign amt      = ShCntW'((2 ** (NormSteps - 1)) >> step_q);
  assign top_zero = (val_q >> (7'(NormW) - 7'(amt))) == '0;

  always_comb begin
    val_d  = val_q;
    sh_d   = sh_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      val_d  = n_i;
      sh_d   = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (top_zero) begin
        val_d = val_q << amt;
        sh_d  = sh_q + amt;
      end
      step_d = step_q + 3'd1;
      if (step_q == 3'(NormSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      sh_q   <= sh_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign expo          = ExpBias - ExpW'(sh_q);
  assign status_o.done = done_q;
  assign status_o.bits = {1'b0, expo, val_q[FracW-1:0]};

endmodule
